### hdl/pwog_pkg.sv
// Shared types, constants and helper functions for the periodic wave offset generator.
`timescale 1ns / 1ps

package pwog_pkg;

  // Restoring divider steps in one chain; every dividend is widened to this.
  localparam int unsigned DivSteps = 32;

  localparam logic [31:0] HASH_MUL_A = 32'h9e3779b9;
  localparam logic [31:0] HASH_MUL_B = 32'h7feb352d;

  // ceil(2^36 / 1000): exact floor division by 1000 for operands below 2^26.
  localparam logic [26:0] RECIP_1000 = 27'd68719477;
  localparam int unsigned RecipShift = 36;

  localparam logic [2:0] REG_WAVE_MODE   = 3'd0;
  localparam logic [2:0] REG_WAVE_PERIOD = 3'd1;
  localparam logic [2:0] REG_WAVE_AMP    = 3'd2;
  localparam logic [2:0] REG_JIT_PERIOD  = 3'd3;
  localparam logic [2:0] REG_JIT_AMP     = 3'd4;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_ZIGZAG = 2'd2;

  // One division in flight: partial remainder, dividend/quotient word, divisor.
  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] word;
    logic [15:0] dvs;
  } lane_t;

  typedef struct packed {
    logic neg;
    logic jit_en;
  } side_t;

  typedef struct packed {
    lane_t a;
    lane_t b;
    side_t side;
  } cell_data_t;

  function automatic logic [15:0] div1000(input logic [25:0] x);
    logic [52:0] prod;
    prod = 53'(x) * 53'(RECIP_1000);
    return prod[RecipShift+15:RecipShift];
  endfunction

endpackage

### hdl/pwog_div_cell.sv
// One restoring-division step for two lanes, with its own valid/ready stage.
`timescale 1ns / 1ps

module pwog_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pwog_pkg::cell_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pwog_pkg::cell_data_t out_data
);
  import pwog_pkg::*;

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;

  function automatic lane_t div_step(input lane_t l);
    logic [16:0] trial;
    lane_t       res;
    trial = {l.rem, l.word[31]};
    res   = l;
    if (trial >= {1'b0, l.dvs}) begin
      res.rem  = 16'(trial - {1'b0, l.dvs});
      res.word = {l.word[30:0], 1'b1};
    end else begin
      res.rem  = trial[15:0];
      res.word = {l.word[30:0], 1'b0};
    end
    return res;
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt      = in_data;
    data_nxt.a    = div_step(in_data.a);
    data_nxt.b    = div_step(in_data.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hdl/pwog_div_chain.sv
// Row of division cells that yields quotient and remainder for two lanes.
`timescale 1ns / 1ps

module pwog_div_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pwog_pkg::cell_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pwog_pkg::cell_data_t out_data
);
  import pwog_pkg::*;

  logic       vld [DivSteps+1];
  logic       rdy [DivSteps+1];
  cell_data_t dat [DivSteps+1];

  assign vld[0]   = in_valid;
  assign dat[0]   = in_data;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    pwog_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_ready (rdy[i]),
      .in_data  (dat[i]),
      .out_valid(vld[i+1]),
      .out_ready(rdy[i+1]),
      .out_data (dat[i+1])
    );
  end

  assign out_valid       = vld[DivSteps];
  assign rdy[DivSteps]   = out_ready;
  assign out_data        = dat[DivSteps];

endmodule

### hdl/periodic_wave_offset_generator.sv
// Top level of the periodic wave offset generator.
`timescale 1ns / 1ps
// Turns an age in milliseconds into a signed vertical offset.
// Input channel: in_valid/in_ready with in_age; output channel: out_valid/out_ready
// with out_offset. Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and registers must only change while no beat is in flight.
// The datapath is two rows of 32 division cells (phase and jitter bucket, then
// wave position and jitter modulo) joined by hash stages and followed by scaling.
// One beat is taken every cycle while the receiver does not stall, since each
// cell forwards its division step to its neighbor every clock. Every stage has
// its own valid bit, so a stalled receiver only holds the output register;
// upstream stages keep filling bubbles until the whole row is full, and then
// in_ready drops. Reset clears all valid bits and loads the register defaults:
// mode none, period 1000, all amplitudes and the jitter period zero.
module periodic_wave_offset_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [23:0] in_age,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic         [2:0] cfg_index,
  input  logic        [15:0] cfg_data
);
  import pwog_pkg::*;

  logic        [1:0]  mode_r;
  logic        [15:0] period_r;
  logic signed [15:0] amp_r;
  logic        [15:0] jper_r;
  logic        [14:0] jamp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NONE;
      period_r <= 16'd1000;
      amp_r    <= '0;
      jper_r   <= '0;
      jamp_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_MODE:   mode_r   <= cfg_data[1:0];
        REG_WAVE_PERIOD: period_r <= cfg_data;
        REG_WAVE_AMP:    amp_r    <= $signed(cfg_data);
        REG_JIT_PERIOD:  jper_r   <= cfg_data;
        REG_JIT_AMP:     jamp_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes, from the output back to the input.
  logic vo_r, v6_r, v5_r, v4_r, v2_r, v1_r, v0_r;
  logic en_o, en6, en5, en4, en2, en1, en0;
  logic c1_in_ready, c1_out_valid, c2_in_ready, c2_out_valid;
  cell_data_t c1_in, c1_out, c2_in, c2_out;

  assign en_o     = !vo_r || out_ready;
  assign en6      = !v6_r || en_o;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en2      = !v2_r || c2_in_ready;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || c1_in_ready;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en0)  v0_r <= in_valid;
      if (en1)  v1_r <= c1_out_valid;
      if (en2)  v2_r <= v1_r;
      if (en4)  v4_r <= c2_out_valid;
      if (en5)  v5_r <= v4_r;
      if (en6)  v6_r <= v5_r;
      if (en_o) vo_r <= v6_r;
    end
  end

  // Input stage: the zigzag wave leads by a quarter period.
  logic [23:0] age0_r;
  logic [24:0] x0_r, x0_nxt;

  assign x0_nxt = (mode_r == MODE_ZIGZAG) ? 25'(in_age) + 25'(period_r[15:2])
                                          : 25'(in_age);

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      age0_r <= in_age;
      x0_r   <= x0_nxt;
    end
  end

  always_comb begin
    c1_in.a.rem  = '0;
    c1_in.a.word = 32'(x0_r);
    c1_in.a.dvs  = period_r;
    c1_in.b.rem  = '0;
    c1_in.b.word = 32'(age0_r);
    c1_in.b.dvs  = jper_r;
    c1_in.side   = '0;
  end

  pwog_div_chain u_phase_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_ready (c1_in_ready),
    .in_data  (c1_in),
    .out_valid(c1_out_valid),
    .out_ready(en1),
    .out_data (c1_out)
  );

  // Stage 1: phase to wave-position dividend, first hash multiply.
  logic [15:0] ph;
  logic [23:0] bucket;
  logic [15:0] half;
  logic        first_half;
  logic [15:0] base;
  logic [26:0] num1_r, num1_nxt;
  logic [15:0] dvs1_r, dvs1_nxt;
  logic        neg1_r, jit1_r;
  logic [31:0] h1_r;

  always_comb begin
    ph         = c1_out.a.rem;
    bucket     = c1_out.b.word[23:0];
    half       = {1'b0, period_r[15:1]};
    first_half = ph < half;
    base       = first_half ? ph : 16'(ph - half);
    if (mode_r == MODE_ZIGZAG) begin
      num1_nxt = 27'(ph) * 27'd2000;
      dvs1_nxt = period_r;
    end else begin
      num1_nxt = 27'(base) * 27'd1000;
      dvs1_nxt = first_half ? half : 16'(period_r - half);
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && c1_out_valid) begin
      num1_r <= num1_nxt;
      dvs1_r <= dvs1_nxt;
      neg1_r <= !first_half;
      jit1_r <= bucket != '0;
      h1_r   <= 32'(32'(bucket) * HASH_MUL_A);
    end
  end

  // Stage 2: second hash multiply.
  logic [26:0] num2_r;
  logic [15:0] dvs2_r;
  logic        neg2_r, jit2_r;
  logic [31:0] h2;
  logic [31:0] h3_r;

  assign h2 = h1_r ^ (h1_r >> 16);

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      num2_r <= num1_r;
      dvs2_r <= dvs1_r;
      neg2_r <= neg1_r;
      jit2_r <= jit1_r;
      h3_r   <= 32'(h2 * HASH_MUL_B);
    end
  end

  always_comb begin
    c2_in.a.rem       = '0;
    c2_in.a.word      = 32'(num2_r);
    c2_in.a.dvs       = dvs2_r;
    c2_in.b.rem       = '0;
    c2_in.b.word      = h3_r ^ (h3_r >> 15);
    c2_in.b.dvs       = {jamp_r, 1'b1};
    c2_in.side.neg    = neg2_r;
    c2_in.side.jit_en = jit2_r;
  end

  pwog_div_chain u_pos_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v2_r),
    .in_ready (c2_in_ready),
    .in_data  (c2_in),
    .out_valid(c2_out_valid),
    .out_ready(en4),
    .out_data (c2_out)
  );

  // Stage 4: parabola product, triangle value, centered jitter.
  logic        [10:0] t;
  logic        [11:0] twice_t;
  logic        [19:0] sq4_r;
  logic signed [11:0] tri4_r, tri4_nxt;
  logic signed [16:0] jit4_r;
  logic               neg4_r, jen4_r;

  always_comb begin
    t        = c2_out.a.word[10:0];
    twice_t  = {t, 1'b0};
    tri4_nxt = (t < 11'd1000) ? $signed(12'(twice_t - 12'd1000))
                              : $signed(12'(12'd3000 - twice_t));
  end

  always_ff @(posedge clk) begin
    if (en4 && c2_out_valid) begin
      sq4_r  <= {18'(18'(t[9:0]) * (18'd1000 - 18'(t[9:0]))), 2'b00};
      tri4_r <= tri4_nxt;
      jit4_r <= $signed(17'(c2_out.b.rem) - 17'(jamp_r));
      neg4_r <= c2_out.side.neg;
      jen4_r <= c2_out.side.jit_en;
    end
  end

  // Stage 5: permille of the selected wave.
  logic        [15:0] w5;
  logic signed [11:0] p5_r, p5_nxt;
  logic signed [16:0] jit5_r;
  logic               jen5_r;

  always_comb begin
    w5 = div1000(26'(sq4_r));
    if (mode_r == MODE_SMOOTH) begin
      p5_nxt = neg4_r ? -$signed(12'(w5)) : $signed(12'(w5));
    end else begin
      p5_nxt = tri4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      p5_r   <= p5_nxt;
      jit5_r <= jit4_r;
      jen5_r <= jen4_r;
    end
  end

  // Stage 6: amplitude scaling.
  logic signed [27:0] m6_r;
  logic signed [16:0] jit6_r;
  logic               jen6_r;

  always_ff @(posedge clk) begin
    if (en6 && v5_r) begin
      m6_r   <= 28'(amp_r) * 28'(p5_r);
      jit6_r <= jit5_r;
      jen6_r <= jen5_r;
    end
  end

  // Output stage: truncating divide by 1000, then add the jitter.
  logic        [27:0] mag;
  logic        [15:0] quo;
  logic signed [16:0] main_term;
  logic               wave_on, jit_on;
  logic signed [16:0] offset_nxt;
  logic signed [16:0] offset_r;

  always_comb begin
    mag       = m6_r[27] ? 28'(-m6_r) : 28'(m6_r);
    quo       = div1000(mag[25:0]);
    main_term = m6_r[27] ? -$signed(17'(quo)) : $signed(17'(quo));
    wave_on   = (mode_r == MODE_SMOOTH || mode_r == MODE_ZIGZAG) && period_r > 16'd1;
    jit_on    = mode_r == MODE_ZIGZAG && jper_r != '0 && jamp_r != '0 && jen6_r;
    offset_nxt = (wave_on ? main_term : 17'sd0) + (jit_on ? jit6_r : 17'sd0);
  end

  always_ff @(posedge clk) begin
    if (en_o && v6_r) begin
      offset_r <= offset_nxt;
    end
  end

  assign out_valid  = vo_r;
  assign out_offset = offset_r;

endmodule
